@@ sv/tkch_pkg.sv @@
// shared types, codes and constants for the top-k closest heap
package tkch_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 1024;
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] OUTCOME_INSERTED  = 2'd0;
  localparam logic [1:0] OUTCOME_REPLACED  = 2'd1;
  localparam logic [1:0] OUTCOME_DISCARDED = 2'd2;
  localparam logic [1:0] OUTCOME_READ      = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] distance;
    logic [31:0] run_tag;
    logic [9:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [31:0]      evicted_tag;
    logic             entry_valid;
    logic [31:0]      entry_distance;
    logic [31:0]      entry_tag;
    logic [CAP_W-1:0] held_count;
    logic [31:0]      worst_distance;
  } result_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] tag;
  } entry_t;

endpackage

@@ sv/tkch_ram.sv @@
// generic synchronous ram, one write port and two registered read ports
module tkch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ sv/tkch_engine.sv @@
// heap sequencer: offers, replacements and reads against the entry ram
module tkch_engine #(
  parameter int MAX_ENTRIES = tkch_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tkch_pkg::CAP_W-1:0] cap,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  tkch_pkg::item_t           item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output tkch_pkg::result_t         res
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int HW = tkch_pkg::CAP_W;
  localparam int EW = (CW > HW) ? CW : HW;
  localparam int XW = (AW + 2 > EW) ? AW + 2 : EW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UP,
    S_DOWN,
    S_PLACE,
    S_RESP
  } state_t;

  state_t             state, state_next;
  logic [AW-1:0]      pos, pos_next;
  logic [CW-1:0]      count, count_next;
  tkch_pkg::entry_t   x, x_next;
  tkch_pkg::entry_t   root, root_next;
  logic [1:0]         outcome, outcome_next;
  logic [31:0]        evicted, evicted_next;
  logic               rvalid, rvalid_next;
  tkch_pkg::entry_t   rentry, rentry_next;

  logic               we;
  logic [AW-1:0]      waddr, ra0, ra1;
  tkch_pkg::entry_t   wdata, rd0, rd1;
  logic [$bits(tkch_pkg::entry_t)-1:0] rd0_raw, rd1_raw;

  logic [XW-1:0] cnt_x, cap_e, max_x, cap_x, idx_x, pos_x;
  logic [XW-1:0] ins_parent, up_parent, up_grand;
  logic [XW-1:0] dn_l, dn_r, dn_child, dn_cl, dn_cr;
  logic          has_room, idx_ok, r_ok, take_l, take_r;
  logic [31:0]   best_d;
  tkch_pkg::entry_t dn_ce;

  tkch_ram #(
    .WIDTH($bits(tkch_pkg::entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr_a(ra0),
    .raddr_b(ra1),
    .rdata_a(rd0_raw),
    .rdata_b(rd1_raw)
  );

  assign rd0 = rd0_raw;
  assign rd1 = rd1_raw;

  assign cnt_x    = XW'(count);
  assign cap_e    = (cap == '0) ? XW'(1) : XW'(cap);
  assign max_x    = XW'(MAX_ENTRIES);
  assign cap_x    = (cap_e > max_x) ? max_x : cap_e;
  assign has_room = cnt_x < cap_x;
  assign idx_x    = XW'(item.read_index);
  assign idx_ok   = idx_x < cnt_x;
  assign pos_x    = XW'(pos);

  assign ins_parent = (cnt_x - XW'(1)) >> 1;
  assign up_parent  = (pos_x - XW'(1)) >> 1;
  assign up_grand   = (up_parent - XW'(1)) >> 1;

  // sift down: larger child wins, left on a tie, only if strictly above x
  assign dn_l     = (pos_x << 1) + XW'(1);
  assign dn_r     = dn_l + XW'(1);
  assign r_ok     = dn_r < cnt_x;
  assign take_l   = rd0.distance > x.distance;
  assign best_d   = take_l ? rd0.distance : x.distance;
  assign take_r   = r_ok && (rd1.distance > best_d);
  assign dn_child = take_r ? dn_r : dn_l;
  assign dn_ce    = take_r ? rd1 : rd0;
  assign dn_cl    = (dn_child << 1) + XW'(1);
  assign dn_cr    = dn_cl + XW'(1);

  assign item_stall = (state != S_IDLE);
  assign res_valid  = (state == S_RESP);

  always_comb begin
    res.outcome        = outcome;
    res.evicted_tag    = evicted;
    res.entry_valid    = rvalid;
    res.entry_distance = rentry.distance;
    res.entry_tag      = rentry.tag;
    res.held_count     = HW'(count);
    res.worst_distance = (count != '0) ? root.distance : 32'd0;
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    count_next   = count;
    x_next       = x;
    outcome_next = outcome;
    evicted_next = evicted;
    rvalid_next  = rvalid;
    rentry_next  = rentry;
    we           = 1'b0;
    waddr        = pos;
    wdata        = x;
    ra0          = '0;
    ra1          = '0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          x_next.distance = item.distance;
          x_next.tag      = item.run_tag;
          evicted_next    = 32'd0;
          rvalid_next     = 1'b0;
          rentry_next     = '0;
          if (item.opcode == tkch_pkg::OP_READ) begin
            outcome_next = tkch_pkg::OUTCOME_READ;
            rvalid_next  = idx_ok;
            ra0          = idx_ok ? idx_x[AW-1:0] : '0;
            state_next   = S_READ;
          end else if (has_room) begin
            outcome_next = tkch_pkg::OUTCOME_INSERTED;
            count_next   = count + CW'(1);
            pos_next     = cnt_x[AW-1:0];
            if (count == '0) begin
              state_next = S_PLACE;
            end else begin
              ra0        = ins_parent[AW-1:0];
              state_next = S_UP;
            end
          end else if (count != '0 && item.distance < root.distance) begin
            outcome_next = tkch_pkg::OUTCOME_REPLACED;
            evicted_next = root.tag;
            pos_next     = '0;
            if (cnt_x > XW'(1)) begin
              ra0        = AW'(1);
              ra1        = (cnt_x > XW'(2)) ? AW'(2) : '0;
              state_next = S_DOWN;
            end else begin
              state_next = S_PLACE;
            end
          end else begin
            outcome_next = tkch_pkg::OUTCOME_DISCARDED;
            evicted_next = item.run_tag;
            state_next   = S_RESP;
          end
        end
      end
      S_READ: begin
        rentry_next = rvalid ? rd0 : '0;
        state_next  = S_RESP;
      end
      S_UP: begin
        we = 1'b1;
        if (rd0.distance < x.distance) begin
          wdata    = rd0;
          pos_next = up_parent[AW-1:0];
          if (up_parent == '0) begin
            state_next = S_PLACE;
          end else begin
            ra0 = up_grand[AW-1:0];
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata    = dn_ce;
          pos_next = dn_child[AW-1:0];
          if (dn_cl < cnt_x) begin
            ra0 = dn_cl[AW-1:0];
            ra1 = (dn_cr < cnt_x) ? dn_cr[AW-1:0] : '0;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // root copy mirrors slot zero
  assign root_next = (we && waddr == '0) ? wdata : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos     <= pos_next;
    x       <= x_next;
    root    <= root_next;
    outcome <= outcome_next;
    evicted <= evicted_next;
    rvalid  <= rvalid_next;
    rentry  <= rentry_next;
  end

endmodule

@@ sv/top_k_closest_heap.sv @@
// top level: capacity register, heap sequencer and result register
//
//   channel   direction  handshake               payload
//   item      in         item_valid/item_stall   tkch_pkg::item_t
//   result    out        result_valid/result_stall tkch_pkg::result_t
//   cfg       in         cfg_we                  cfg_wdata (capacity_in_use)
//
// one transaction at a time; a read passes through S_READ, a discard goes straight to S_RESP,
// and an insert or replace moves one heap level per sequencer step (up to log2 of
// MAX_ENTRIES levels), each step waiting on the registered read of the entry ram
// synchronous reset clears the count and sequencer; ram contents are not cleared
// a stalled result is held in the output register while the next transaction runs
module top_k_closest_heap #(
  parameter int MAX_ENTRIES = tkch_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tkch_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  tkch_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tkch_pkg::result_t          result
);

  logic [tkch_pkg::CAP_W-1:0] cap;
  logic                       res_valid, res_stall;
  tkch_pkg::result_t          res;

  tkch_engine #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .cap(cap),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  assign res_stall = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= tkch_pkg::CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (res_valid && !res_stall) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (res_valid && !res_stall) begin
      result <= res;
    end
  end

endmodule

@@ tb/top_k_closest_heap_tb.sv @@
// testbench for top_k_closest_heap: directed and random offers and reads, scoreboard checked
module top_k_closest_heap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = tkch_pkg::DEFAULT_MAX_ENTRIES;

  class heap_scoreboard;
    bit [31:0] slot_dist [SLOTS];
    bit [31:0] slot_tag [SLOTS];
    int unsigned held;
    bit [tkch_pkg::CAP_W-1:0] capacity;
    tkch_pkg::result_t expected_results [$];
    int failures;

    function new();
      held = 0;
      capacity = tkch_pkg::CAP_RESET;
      failures = 0;
    endfunction

    function void set_capacity(bit [tkch_pkg::CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned keep_limit();
      int unsigned k;
      k = capacity;
      if (k == 0) k = 1;
      if (k > SLOTS) k = SLOTS;
      return k;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      bit [31:0] d;
      bit [31:0] t;
      d = slot_dist[a];
      t = slot_tag[a];
      slot_dist[a] = slot_dist[b];
      slot_tag[a] = slot_tag[b];
      slot_dist[b] = d;
      slot_tag[b] = t;
    endfunction

    function void float_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (slot_dist[parent] >= slot_dist[pos]) break;
        swap_slots(parent, pos);
        pos = parent;
      end
    endfunction

    function void sink_root();
      int unsigned pos;
      int unsigned best;
      int unsigned l;
      int unsigned r;
      pos = 0;
      forever begin
        best = pos;
        l = 2 * pos + 1;
        r = 2 * pos + 2;
        if (l < held && slot_dist[l] > slot_dist[best]) best = l;
        if (r < held && slot_dist[r] > slot_dist[best]) best = r;
        if (best == pos) break;
        swap_slots(best, pos);
        pos = best;
      end
    endfunction

    function void accept_item(tkch_pkg::item_t it);
      tkch_pkg::result_t r;
      r = '0;
      if (it.opcode == tkch_pkg::OP_READ) begin
        r.outcome = tkch_pkg::OUTCOME_READ;
        if (it.read_index < held) begin
          r.entry_valid = 1'b1;
          r.entry_distance = slot_dist[it.read_index];
          r.entry_tag = slot_tag[it.read_index];
        end
      end else if (held < keep_limit()) begin
        slot_dist[held] = it.distance;
        slot_tag[held] = it.run_tag;
        held++;
        float_up(held - 1);
        r.outcome = tkch_pkg::OUTCOME_INSERTED;
      end else if (held > 0 && it.distance < slot_dist[0]) begin
        r.evicted_tag = slot_tag[0];
        slot_dist[0] = it.distance;
        slot_tag[0] = it.run_tag;
        sink_root();
        r.outcome = tkch_pkg::OUTCOME_REPLACED;
      end else begin
        r.evicted_tag = it.run_tag;
        r.outcome = tkch_pkg::OUTCOME_DISCARDED;
      end
      r.held_count = tkch_pkg::CAP_W'(held);
      r.worst_distance = (held > 0) ? slot_dist[0] : 32'd0;
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        failures++;
        $display("%0t %s mismatch: expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(tkch_pkg::result_t got);
      tkch_pkg::result_t want;
      if (pending() == 0) begin
        failures++;
        $display("%0t result transaction with none expected: expected none actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      field_check("outcome", want.outcome, got.outcome);
      field_check("evicted_tag", want.evicted_tag, got.evicted_tag);
      field_check("entry_valid", want.entry_valid, got.entry_valid);
      field_check("entry_distance", want.entry_distance, got.entry_distance);
      field_check("entry_tag", want.entry_tag, got.entry_tag);
      field_check("held_count", want.held_count, got.held_count);
      field_check("worst_distance", want.worst_distance, got.worst_distance);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [tkch_pkg::CAP_W-1:0] cfg_wdata;
  logic                       item_valid;
  logic                       item_stall;
  tkch_pkg::item_t            item;
  logic                       result_valid;
  logic                       result_stall;
  tkch_pkg::result_t          result;

  heap_scoreboard sb = new();
  bit sender_gaps = 1'b1;
  bit quiet = 1'b0;
  int hold_request = 0;

  top_k_closest_heap #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tkch_pkg::item_t make_item(logic op, logic [31:0] offer_distance,
                                                logic [31:0] tag, logic [9:0] idx);
    tkch_pkg::item_t it;
    it.opcode = op;
    it.distance = offer_distance;
    it.run_tag = tag;
    it.read_index = idx;
    return it;
  endfunction

  function automatic tkch_pkg::item_t random_item();
    tkch_pkg::item_t it;
    int unsigned span;
    int pick;
    it.opcode = ($urandom_range(0, 9) < 7) ? tkch_pkg::OP_OFFER : tkch_pkg::OP_READ;
    pick = $urandom_range(0, 9);
    if (pick < 5) it.distance = $urandom_range(0, 31);
    else if (pick < 8) it.distance = $urandom;
    else if (pick == 8) it.distance = 32'd0;
    else it.distance = 32'hFFFF_FFFF;
    it.run_tag = $urandom;
    pick = $urandom_range(0, 9);
    span = sb.held + 1;
    if (span > 1023) span = 1023;
    if (pick < 7) it.read_index = 10'($urandom_range(0, span));
    else if (pick < 9) it.read_index = 10'($urandom);
    else it.read_index = 10'd1023;
    return it;
  endfunction

  task automatic send_item(tkch_pkg::item_t it);
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.accept_item(it);
  endtask

  task automatic send_random(int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [tkch_pkg::CAP_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  // result side: check accepted transactions, then pick the next stall value
  initial begin : result_side
    int burst_left;
    int hold_cycles;
    burst_left = 0;
    hold_cycles = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold_request > 0) begin
        hold_cycles = hold_request;
        hold_request = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 6) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    item_valid <= 1'b0;
    item <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty heap reads at both ends of the index range
    send_item(make_item(tkch_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0));
    send_item(make_item(tkch_pkg::OP_READ, 32'd0, 32'd0, 10'd1023));

    // capacity zero keeps one entry
    write_capacity(11'd0);
    send_item(make_item(tkch_pkg::OP_OFFER, 32'd100, 32'hFFFF_FFFF, 10'h3FF));
    send_item(make_item(tkch_pkg::OP_OFFER, 32'd100, 32'h0000_0002, 10'd0));
    send_item(make_item(tkch_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'h0000_0003, 10'd0));
    send_item(make_item(tkch_pkg::OP_OFFER, 32'd50, 32'h0000_0004, 10'd0));
    send_item(make_item(tkch_pkg::OP_OFFER, 32'd0, 32'd0, 10'd0));
    send_item(make_item(tkch_pkg::OP_OFFER, 32'd0, 32'h0000_0006, 10'd0));
    send_item(make_item(tkch_pkg::OP_READ, 32'd0, 32'd0, 10'd0));
    send_item(make_item(tkch_pkg::OP_READ, 32'd0, 32'd0, 10'd1));
    send_random(40);

    write_capacity(11'd1);
    send_random(30);

    write_capacity(11'd2);
    send_random(50);

    write_capacity(11'd7);
    send_random(80);

    // long receiver hold-off so the block backs up into its input
    write_capacity(11'd16);
    hold_request = 400;
    send_random(120);

    // capacity below the held count
    write_capacity(11'd3);
    send_random(60);

    // above the array size, saturates
    write_capacity(11'd2047);
    sender_gaps = 1'b0;
    send_random(150);
    sender_gaps = 1'b1;

    write_capacity(11'd1024);
    send_random(120);

    write_capacity(11'd40);
    quiet = 1'b1;
    send_random(100);

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ top_k_closest_heap.f @@
sv/tkch_pkg.sv
sv/tkch_ram.sv
sv/tkch_engine.sv
sv/top_k_closest_heap.sv
tb/top_k_closest_heap_tb.sv
